// ----- hw/rtl/length_prefixed_message_deframer_core_macros.svh -----
// Assertion macros used by the deframer parser RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef LENGTH_PREFIXED_MESSAGE_DEFRAMER_CORE_MACROS_SVH
`define LENGTH_PREFIXED_MESSAGE_DEFRAMER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define LPMD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication
`define LPMD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LPMD_ASSERT_IMPL(label, ante, cons, msg)
`define LPMD_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ----- hw/rtl/lpmd_pkg.sv -----
package lpmd_pkg;

  // Field codes; the parser phase uses the same encoding
  localparam logic [1:0] PhNameLen = 2'd0;
  localparam logic [1:0] PhName    = 2'd1;
  localparam logic [1:0] PhPayLen  = 2'd2;
  localparam logic [1:0] PhPay     = 2'd3;

  // Bytes in each big-endian length prefix
  localparam logic [31:0] LenBytes = 32'd4;

  // One tagged output byte
  typedef struct packed {
    logic [1:0]  field_kind;
    logic [7:0]  data_byte;
    logic        field_last;
    logic        message_last;
    logic [31:0] length_value;
  } lpmd_result_t;

endpackage

// ----- hw/rtl/lpmd_in_if.sv -----
interface lpmd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// ----- hw/rtl/lpmd_out_if.sv -----
interface lpmd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  field_kind;
  logic [7:0]  data_byte;
  logic        field_last;
  logic        message_last;
  logic [31:0] length_value;

  modport source (output valid, output field_kind, output data_byte, output field_last,
                  output message_last, output length_value, input ready);
  modport sink   (input valid, input field_kind, input data_byte, input field_last,
                  input message_last, input length_value, output ready);
endinterface

// ----- hw/rtl/length_prefixed_message_deframer_core.sv -----
// Length-prefixed message deframer.
// in_i takes one raw link byte per transfer. Messages are framed as a 4-byte
// big-endian name length, the name bytes, a 4-byte big-endian payload length
// and the payload bytes; a zero length skips its field.
// out_o gives one tagged byte per input byte: field_kind, the byte itself,
// field_last, message_last, and the decoded length on the last byte of a
// length field (zero otherwise).
// out_o.valid is registered: each byte passes through the input register, then
// the result register, before its result can transfer on out_o. Throughput:
// one byte per cycle while out_o.ready stays high, set by the single
// counter/compare step between the two registers.
// Reset clears both registers' valid bits and returns the parser to the
// start of a name length field with all counts zero.
// When the receiver holds out_o.ready low, the result register keeps its
// byte, the input register takes one more byte only if it is empty, and
// in_i.ready stays low until the result is taken; nothing is dropped or
// repeated.
module length_prefixed_message_deframer_core
  import lpmd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  lpmd_in_if.sink    in_i,
  lpmd_out_if.source out_o
);

  logic         in_valid;
  logic [7:0]   in_byte;
  logic         take;
  logic         advance;
  lpmd_result_t result;

  assign advance = in_valid && take;

  lpmd_in_stage u_in_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .advance_i(advance),
    .valid_o  (in_valid),
    .byte_o   (in_byte)
  );

  lpmd_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .advance_i(advance),
    .byte_i   (in_byte),
    .result_o (result)
  );

  lpmd_out_stage u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid),
    .result_i(result),
    .take_o  (take),
    .out_o   (out_o)
  );

endmodule

// ----- hw/rtl/lpmd_in_stage.sv -----
module lpmd_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  lpmd_in_if.sink    in_i,
  input  logic       advance_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q;
  logic [7:0] byte_q;
  logic       load;

  // Refill whenever the held byte is empty or moves on this cycle
  assign in_i.ready = !valid_q || advance_i;
  assign load       = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= in_i.in_byte;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

// ----- hw/rtl/lpmd_parser.sv -----
`include "length_prefixed_message_deframer_core_macros.svh"

module lpmd_parser
  import lpmd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         advance_i,
  input  logic [7:0]   byte_i,
  output lpmd_result_t result_o
);

  logic [1:0]  phase_q, phase_d;
  logic [31:0] count_q, count_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] flen_q, flen_d;

  logic [31:0] cnt_inc;
  logic [31:0] acc_shift;
  logic        is_len;
  logic        done;

  assign cnt_inc   = count_q + 32'd1;
  assign acc_shift = {acc_q[23:0], byte_i};
  assign is_len    = (phase_q == PhNameLen) || (phase_q == PhPayLen);
  assign done      = is_len ? (cnt_inc >= LenBytes) : (cnt_inc >= flen_q);

  // Tag the byte and work out the next field position
  always_comb begin
    phase_d = phase_q;
    count_d = done ? 32'd0 : cnt_inc;
    acc_d   = acc_q;
    flen_d  = flen_q;

    result_o.field_kind   = phase_q;
    result_o.data_byte    = byte_i;
    result_o.field_last   = done;
    result_o.message_last = 1'b0;
    result_o.length_value = 32'd0;

    if (is_len) begin
      acc_d = done ? 32'd0 : acc_shift;
      if (done) begin
        result_o.length_value = acc_shift;
        flen_d = acc_shift;
        case (phase_q)
          PhNameLen: begin
            // empty name skips straight to the payload length
            phase_d = (acc_shift == 32'd0) ? PhPayLen : PhName;
          end
          default: begin
            // empty payload ends the message here
            if (acc_shift == 32'd0) begin
              result_o.message_last = 1'b1;
              phase_d = PhNameLen;
            end else begin
              phase_d = PhPay;
            end
          end
        endcase
      end
    end else if (done) begin
      case (phase_q)
        PhName: begin
          phase_d = PhPayLen;
        end
        default: begin
          result_o.message_last = 1'b1;
          phase_d = PhNameLen;
        end
      endcase
    end
  end

  // State moves only when a byte transfers to the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhNameLen;
      count_q <= 32'd0;
      acc_q   <= 32'd0;
      flen_q  <= 32'd0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      acc_q   <= acc_d;
      flen_q  <= flen_d;
    end
  end

  `LPMD_ASSERT_IMPL(a_msg_last_ends_field, result_o.message_last, result_o.field_last, "message_last without field_last")
  `LPMD_ASSERT_IMPL(a_len_only_on_len_end, result_o.length_value != 32'd0, result_o.field_last && is_len, "length_value outside a finished length field")
  `LPMD_ASSERT_IMPL(a_count_in_field, (phase_q == PhName) || (phase_q == PhPay), count_q < flen_q, "byte count ran past field length")
  `LPMD_ASSERT_NEXT(a_count_clears, advance_i && done, count_q == 32'd0, "byte count not cleared at field end")

endmodule

// ----- hw/rtl/lpmd_out_stage.sv -----
module lpmd_out_stage
  import lpmd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  input  lpmd_result_t result_i,
  output logic         take_o,
  lpmd_out_if.source   out_o
);

  logic         valid_q;
  lpmd_result_t result_q;

  // Free slot or the receiver drains it this cycle
  assign take_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && valid_i) begin
      result_q <= result_i;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.field_kind   = result_q.field_kind;
  assign out_o.data_byte    = result_q.data_byte;
  assign out_o.field_last   = result_q.field_last;
  assign out_o.message_last = result_q.message_last;
  assign out_o.length_value = result_q.length_value;

endmodule

// ----- tb/tb_length_prefixed_message_deframer_core.sv -----
`timescale 1ns / 100ps

module tb_length_prefixed_message_deframer_core;
  import lpmd_pkg::*;

  // One directed stimulus row; exp is used only when typed is set
  typedef struct packed {
    logic [7:0]   b;
    logic         typed;
    lpmd_result_t exp;
  } dir_row_t;

  localparam int NumDir = 19;

  // Empty name and payload, then a one-byte name and a two-byte payload
  dir_row_t dir_tbl [NumDir] = '{
    '{8'h00, 1'b1, '{PhNameLen, 8'h00, 1'b0, 1'b0, 32'd0}},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b1, '{PhNameLen, 8'h00, 1'b1, 1'b0, 32'd0}},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b1, '{PhPayLen, 8'h00, 1'b1, 1'b1, 32'd0}},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h01, 1'b1, '{PhNameLen, 8'h01, 1'b1, 1'b0, 32'd1}},
    '{8'hff, 1'b1, '{PhName, 8'hff, 1'b1, 1'b0, 32'd0}},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h02, 1'b1, '{PhPayLen, 8'h02, 1'b1, 1'b0, 32'd2}},
    '{8'h80, 1'b0, '0},
    '{8'h7f, 1'b1, '{PhPay, 8'h7f, 1'b1, 1'b1, 32'd0}}
  };

  logic clk_i;
  logic rst_ni;

  lpmd_in_if  in_if ();
  lpmd_out_if out_if ();

  length_prefixed_message_deframer_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Parser state mirror
  logic [1:0]  cur_field;
  logic [31:0] fld_cnt;
  logic [31:0] len_acc;
  logic [31:0] fld_len;

  lpmd_result_t tagged_q [$];
  int  n_errors;
  int  n_sent;
  bit  idle_on;
  bit  hold_req;
  int  hold_left;

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Tag one byte and advance the mirrored parser
  function automatic lpmd_result_t deframe_byte(input logic [7:0] b);
    lpmd_result_t r;
    r = '0;
    r.field_kind = cur_field;
    r.data_byte  = b;
    if (cur_field == PhNameLen || cur_field == PhPayLen) begin
      len_acc = {len_acc[23:0], b};
      fld_cnt = fld_cnt + 32'd1;
      if (fld_cnt >= LenBytes) begin
        r.field_last   = 1'b1;
        r.length_value = len_acc;
        fld_len = len_acc;
        fld_cnt = '0;
        len_acc = '0;
        if (cur_field == PhNameLen) begin
          cur_field = (fld_len == '0) ? PhPayLen : PhName;
        end else if (fld_len == '0) begin
          r.message_last = 1'b1;
          cur_field = PhNameLen;
        end else begin
          cur_field = PhPay;
        end
      end
    end else begin
      fld_cnt = fld_cnt + 32'd1;
      if (fld_cnt >= fld_len) begin
        r.field_last = 1'b1;
        fld_cnt = '0;
        if (cur_field == PhName) begin
          cur_field = PhPayLen;
        end else begin
          r.message_last = 1'b1;
          cur_field = PhNameLen;
        end
      end
    end
    return r;
  endfunction

  // Offer one byte at the falling edge, with random gaps, until the transfer
  task automatic push_byte(input logic [7:0] b, input logic typed, input lpmd_result_t exp);
    lpmd_result_t pred;
    @(negedge clk_i);
    while (idle_on && $urandom_range(99) < 8) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.in_byte <= b;
    do @(posedge clk_i); while (!in_if.ready);
    pred = deframe_byte(b);
    tagged_q.push_back(typed ? exp : pred);
    n_sent++;
  endtask

  // Big-endian length prefix of four bytes
  task automatic push_length(input logic [31:0] len);
    for (int i = 3; i >= 0; i--) push_byte(len[8*i +: 8], 1'b0, '0);
  endtask

  // One well-formed message with random name and payload bytes
  task automatic push_message();
    int name_len;
    int pay_len;
    int sel;
    sel = $urandom_range(99);
    name_len = (sel < 25) ? 0 : $urandom_range(6, 1);
    sel = $urandom_range(99);
    if (sel < 25) pay_len = 0;
    else if (sel < 95) pay_len = $urandom_range(12, 1);
    else pay_len = $urandom_range(200, 40);
    push_length(name_len);
    for (int i = 0; i < name_len; i++) push_byte(8'($urandom_range(255)), 1'b0, '0);
    push_length(pay_len);
    for (int i = 0; i < pay_len; i++) push_byte(8'($urandom_range(255)), 1'b0, '0);
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = 80;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= !(idle_on && $urandom_range(99) < 8);
    end
  end

  // Compare each result transfer with the oldest tagged byte
  always @(posedge clk_i) begin
    lpmd_result_t got;
    lpmd_result_t exp;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = '{out_if.field_kind, out_if.data_byte, out_if.field_last,
              out_if.message_last, out_if.length_value};
      if (tagged_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        n_errors++;
      end else begin
        exp = tagged_q.pop_front();
        if (got.field_kind !== exp.field_kind) begin
          $display("%0t: field_kind exp %0d got %0d", $time, exp.field_kind, got.field_kind);
          n_errors++;
        end
        if (got.data_byte !== exp.data_byte) begin
          $display("%0t: data_byte exp %h got %h", $time, exp.data_byte, got.data_byte);
          n_errors++;
        end
        if (got.field_last !== exp.field_last) begin
          $display("%0t: field_last exp %b got %b", $time, exp.field_last, got.field_last);
          n_errors++;
        end
        if (got.message_last !== exp.message_last) begin
          $display("%0t: message_last exp %b got %b", $time, exp.message_last,
                   got.message_last);
          n_errors++;
        end
        if (got.length_value !== exp.length_value) begin
          $display("%0t: length_value exp %h got %h", $time, exp.length_value,
                   got.length_value);
          n_errors++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    #2ms;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    bit held;
    bit drained;
    cur_field = PhNameLen;
    fld_cnt   = '0;
    len_acc   = '0;
    fld_len   = '0;
    n_errors  = 0;
    n_sent    = 0;
    idle_on   = 1'b1;
    hold_req  = 1'b0;
    hold_left = 0;
    held      = 1'b0;
    drained   = 1'b0;
    in_if.valid   = 1'b0;
    in_if.in_byte = '0;
    out_if.ready  = 1'b0;
    rst_ni = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part
    for (int i = 0; i < NumDir; i++) begin
      push_byte(dir_tbl[i].b, dir_tbl[i].typed, dir_tbl[i].exp);
    end

    // Random well-formed messages
    while (n_sent < 1400) begin
      if (!held && n_sent >= 400) begin
        held = 1'b1;
        hold_req = 1'b1;
      end
      if (!drained && n_sent >= 700) begin
        drained = 1'b1;
        // Withdraw the last byte before waiting for the results
        @(negedge clk_i);
        in_if.valid <= 1'b0;
        while (tagged_q.size() != 0) @(posedge clk_i);
      end
      idle_on = !(n_sent >= 900 && n_sent < 1100);
      push_message();
    end
    idle_on = 1'b1;

    // Longest name length; only its first bytes are sent
    push_length(32'hffff_ffff);
    for (int i = 0; i < 16; i++) push_byte(8'($urandom_range(255)), 1'b0, '0);

    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (tagged_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (n_errors == 0 && tagged_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/lpmd_pkg.sv
hw/rtl/lpmd_in_if.sv
hw/rtl/lpmd_out_if.sv
hw/rtl/lpmd_in_stage.sv
hw/rtl/lpmd_parser.sv
hw/rtl/lpmd_out_stage.sv
hw/rtl/length_prefixed_message_deframer_core.sv
tb/tb_length_prefixed_message_deframer_core.sv
